FILE: hw/rtl/ppo_pkg.sv
// ----------------------------------------------------------------------------
// ppo_pkg
// Types, constants and the quarter-wave sine table for polar_point_offset.
// ----------------------------------------------------------------------------
package ppo_pkg;

  typedef struct packed {
    logic               mode;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic [7:0]         distance;
    logic signed [15:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        error;
  } result_t;

  localparam logic MODE_END  = 1'b0;
  localparam logic MODE_LINE = 1'b1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [8:0]  FULL_TURN    = 9'd360;
  localparam logic [6:0]  QUARTER_TURN = 7'd90;
  localparam logic [13:0] SINE_SCALE   = 14'd10000;

  // 92 full turns: lifts any 16-bit signed angle to a non-negative value
  localparam logic [16:0] ANG_BIAS = 17'd33120;

  // floor(2^24 / 360) and floor(2^30 / 10000); both give the quotient or one less
  localparam logic [15:0] RECIP_TURN  = 16'd46603;
  localparam int          TURN_SHIFT  = 24;
  localparam logic [16:0] RECIP_SCALE = 17'd107374;
  localparam int          SCALE_SHIFT = 30;

  // round(10000 * sin(k deg)), k = 0..90
  function automatic logic [13:0] sine_lut(input logic [6:0] idx);
    logic [13:0] v;
    case (idx)
      7'd0:  v = 14'd0;     7'd1:  v = 14'd175;   7'd2:  v = 14'd349;
      7'd3:  v = 14'd523;   7'd4:  v = 14'd698;   7'd5:  v = 14'd872;
      7'd6:  v = 14'd1045;  7'd7:  v = 14'd1219;  7'd8:  v = 14'd1392;
      7'd9:  v = 14'd1564;  7'd10: v = 14'd1736;  7'd11: v = 14'd1908;
      7'd12: v = 14'd2079;  7'd13: v = 14'd2250;  7'd14: v = 14'd2419;
      7'd15: v = 14'd2588;  7'd16: v = 14'd2756;  7'd17: v = 14'd2924;
      7'd18: v = 14'd3090;  7'd19: v = 14'd3256;  7'd20: v = 14'd3420;
      7'd21: v = 14'd3584;  7'd22: v = 14'd3746;  7'd23: v = 14'd3907;
      7'd24: v = 14'd4067;  7'd25: v = 14'd4226;  7'd26: v = 14'd4384;
      7'd27: v = 14'd4540;  7'd28: v = 14'd4695;  7'd29: v = 14'd4848;
      7'd30: v = 14'd5000;  7'd31: v = 14'd5150;  7'd32: v = 14'd5299;
      7'd33: v = 14'd5446;  7'd34: v = 14'd5592;  7'd35: v = 14'd5736;
      7'd36: v = 14'd5878;  7'd37: v = 14'd6018;  7'd38: v = 14'd6157;
      7'd39: v = 14'd6293;  7'd40: v = 14'd6428;  7'd41: v = 14'd6561;
      7'd42: v = 14'd6691;  7'd43: v = 14'd6820;  7'd44: v = 14'd6947;
      7'd45: v = 14'd7071;  7'd46: v = 14'd7193;  7'd47: v = 14'd7314;
      7'd48: v = 14'd7431;  7'd49: v = 14'd7547;  7'd50: v = 14'd7660;
      7'd51: v = 14'd7771;  7'd52: v = 14'd7880;  7'd53: v = 14'd7986;
      7'd54: v = 14'd8090;  7'd55: v = 14'd8192;  7'd56: v = 14'd8290;
      7'd57: v = 14'd8387;  7'd58: v = 14'd8480;  7'd59: v = 14'd8572;
      7'd60: v = 14'd8660;  7'd61: v = 14'd8746;  7'd62: v = 14'd8829;
      7'd63: v = 14'd8910;  7'd64: v = 14'd8988;  7'd65: v = 14'd9063;
      7'd66: v = 14'd9135;  7'd67: v = 14'd9205;  7'd68: v = 14'd9272;
      7'd69: v = 14'd9336;  7'd70: v = 14'd9397;  7'd71: v = 14'd9455;
      7'd72: v = 14'd9511;  7'd73: v = 14'd9563;  7'd74: v = 14'd9613;
      7'd75: v = 14'd9659;  7'd76: v = 14'd9703;  7'd77: v = 14'd9744;
      7'd78: v = 14'd9781;  7'd79: v = 14'd9816;  7'd80: v = 14'd9848;
      7'd81: v = 14'd9877;  7'd82: v = 14'd9903;  7'd83: v = 14'd9925;
      7'd84: v = 14'd9945;  7'd85: v = 14'd9962;  7'd86: v = 14'd9976;
      7'd87: v = 14'd9986;  7'd88: v = 14'd9994;  7'd89: v = 14'd9998;
      7'd90: v = 14'd10000;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/polar_point_offset.sv
// ----------------------------------------------------------------------------
// polar_point_offset
// Pixel at a given distance and whole-degree angle from a centre point.
// ----------------------------------------------------------------------------
// Takes one item per clock: busy is always low and start may be held high
// every cycle. Each item gives exactly one result, shown on result with done
// high for one cycle, in issue order. done comes from a valid shift register
// that runs alongside the data stages.
// The seven register stages are angle bias and reciprocal multiply, modulo-360
// correction, quadrant split, table lookup and distance multiply, reciprocal
// multiply for the /10000, quotient correction and clamp, and the quadrant
// add/subtract into the output register. There is no back-pressure: the
// receiver must take every result in the cycle it is shown.
module polar_point_offset
  import ppo_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  typedef struct packed {
    logic        mode;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [7:0]  distance;
    logic        err;
  } meta_t;

  logic [6:0] valid;
  meta_t      s1_m, s2_m, s3_m, s4_m, s5_m, s6_m;

  // stage 1: bias the angle, estimate the turn count
  logic [16:0] ang_u;
  logic [32:0] turn_prod;
  logic        line_err;
  logic [16:0] s1_u;
  logic [7:0]  s1_q;
  logic [8:0]  s1_line_norm;

  assign ang_u     = {cmd.angle[15], cmd.angle} + ANG_BIAS;
  assign turn_prod = 33'(ang_u) * 33'(RECIP_TURN);
  // sign bit catches negative angles
  assign line_err  = (cmd.mode == MODE_LINE) && (cmd.angle > 16'sd360 || cmd.angle[15]);

  always_ff @(posedge clk) begin
    s1_u         <= ang_u;
    s1_q         <= turn_prod[TURN_SHIFT +: 8];
    s1_line_norm <= (cmd.angle == 16'sd360) ? 9'd0 : cmd.angle[8:0];
    s1_m         <= '{mode: cmd.mode, cx: cmd.center_x, cy: cmd.center_y,
                      distance: cmd.distance, err: line_err};
  end

  // stage 2: remainder and one correction step
  logic [16:0] turn_rem;
  logic [9:0]  rem_w;
  logic [8:0]  end_norm;
  logic [8:0]  s2_norm;

  assign turn_rem = s1_u - 17'(17'(s1_q) * 17'(FULL_TURN));
  assign rem_w    = turn_rem[9:0];
  assign end_norm = (rem_w >= 10'(FULL_TURN)) ? 9'(rem_w - 10'(FULL_TURN)) : rem_w[8:0];

  always_ff @(posedge clk) begin
    s2_norm <= (s1_m.mode == MODE_LINE) ? s1_line_norm : end_norm;
    s2_m    <= s1_m;
  end

  // stage 3: quadrant and angle within it
  logic [1:0] quad_c;
  logic [8:0] sub_w;
  logic [1:0] s3_quad;
  logic [6:0] s3_sub;

  always_comb begin
    if (s2_norm >= 9'd270) begin
      quad_c = QUAD_3;
      sub_w  = s2_norm - 9'd270;
    end else if (s2_norm >= 9'd180) begin
      quad_c = QUAD_2;
      sub_w  = s2_norm - 9'd180;
    end else if (s2_norm >= 9'(QUARTER_TURN)) begin
      quad_c = QUAD_1;
      sub_w  = s2_norm - 9'(QUARTER_TURN);
    end else begin
      quad_c = QUAD_0;
      sub_w  = s2_norm;
    end
  end

  always_ff @(posedge clk) begin
    s3_quad <= quad_c;
    s3_sub  <= sub_w[6:0];
    s3_m    <= s2_m;
  end

  // stage 4: sine lookups and distance products
  logic [13:0] sin_h, sin_l;
  logic [1:0]  s4_quad;
  logic [21:0] s4_ph, s4_pl;

  assign sin_h = sine_lut(s3_sub);
  assign sin_l = sine_lut(QUARTER_TURN - s3_sub);

  always_ff @(posedge clk) begin
    s4_ph   <= 22'(s3_m.distance) * 22'(sin_h);
    s4_pl   <= 22'(s3_m.distance) * 22'(sin_l);
    s4_quad <= s3_quad;
    s4_m    <= s3_m;
  end

  // stage 5: reciprocal multiply for the /10000
  logic [38:0] h_prod, l_prod;
  logic [21:0] s5_ph, s5_pl;
  logic [7:0]  s5_qh, s5_ql;
  logic [1:0]  s5_quad;

  assign h_prod = 39'(s4_ph) * 39'(RECIP_SCALE);
  assign l_prod = 39'(s4_pl) * 39'(RECIP_SCALE);

  always_ff @(posedge clk) begin
    s5_ph   <= s4_ph;
    s5_pl   <= s4_pl;
    s5_qh   <= h_prod[SCALE_SHIFT +: 8];
    s5_ql   <= l_prod[SCALE_SHIFT +: 8];
    s5_quad <= s4_quad;
    s5_m    <= s4_m;
  end

  // stage 6: quotient correction, then end-mode clamp
  logic [21:0] h_rem, l_rem;
  logic [7:0]  h_q, l_q;
  logic [8:0]  h_c, l_c;
  logic [8:0]  s6_h, s6_l;
  logic [1:0]  s6_quad;

  assign h_rem = s5_ph - 22'(22'(s5_qh) * 22'(SINE_SCALE));
  assign l_rem = s5_pl - 22'(22'(s5_ql) * 22'(SINE_SCALE));
  assign h_q   = (h_rem >= 22'(SINE_SCALE)) ? s5_qh + 8'd1 : s5_qh;
  assign l_q   = (l_rem >= 22'(SINE_SCALE)) ? s5_ql + 8'd1 : s5_ql;
  // in end mode an offset equal to the distance is pulled in by one; zero distance gives -1
  assign h_c   = (s5_m.mode == MODE_END && h_q == s5_m.distance) ? {1'b0, h_q} - 9'd1
                                                                 : {1'b0, h_q};
  assign l_c   = (s5_m.mode == MODE_END && l_q == s5_m.distance) ? {1'b0, l_q} - 9'd1
                                                                 : {1'b0, l_q};

  always_ff @(posedge clk) begin
    s6_h    <= h_c;
    s6_l    <= l_c;
    s6_quad <= s5_quad;
    s6_m    <= s5_m;
  end

  // stage 7: fold into the quadrant
  logic [15:0] x_c, y_c;
  logic [15:0] h_w, l_w;

  assign h_w = {{7{s6_h[8]}}, s6_h};
  assign l_w = {{7{s6_l[8]}}, s6_l};

  always_comb begin
    case (s6_quad)
      QUAD_0: begin
        x_c = s6_m.cx + l_w;
        y_c = s6_m.cy + h_w;
      end
      QUAD_1: begin
        x_c = s6_m.cx - h_w;
        y_c = s6_m.cy + l_w;
      end
      QUAD_2: begin
        x_c = s6_m.cx - l_w;
        y_c = s6_m.cy - h_w;
      end
      default: begin
        x_c = s6_m.cx + h_w;
        y_c = s6_m.cy - l_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result.point_x <= s6_m.err ? 16'd0 : x_c;
    result.point_y <= s6_m.err ? 16'd0 : y_c;
    result.error   <= s6_m.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:0], start & ~busy};
    end
  end

  assign busy = 1'b0;
  assign done = valid[6];

endmodule

FILE: bench/polar_point_offset_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_point_offset_tb
// Self-checking bench for the polar to Cartesian pixel offset block.
// ----------------------------------------------------------------------------
// An initial block queues a directed set (table ends, quadrant edges, zero and
// full distance, out-of-range line angles) and then random items. A clocked
// driver issues them with random idle bursts; a clocked monitor predicts the
// point of every accepted item and compares each strobed result in order.
// ----------------------------------------------------------------------------
module polar_point_offset_tb;
  import ppo_pkg::*;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int QUIET_TAIL     = 200;
  localparam int STALL_LIMIT    = 1000;
  localparam int TRAIL_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;

  // round(10000 * sin(k deg)), k = 0..90
  int unsigned quarter_sine [0:90] = '{
       0,  175,  349,  523,  698,  872, 1045, 1219, 1392, 1564,
    1736, 1908, 2079, 2250, 2419, 2588, 2756, 2924, 3090, 3256,
    3420, 3584, 3746, 3907, 4067, 4226, 4384, 4540, 4695, 4848,
    5000, 5150, 5299, 5446, 5592, 5736, 5878, 6018, 6157, 6293,
    6428, 6561, 6691, 6820, 6947, 7071, 7193, 7314, 7431, 7547,
    7660, 7771, 7880, 7986, 8090, 8192, 8290, 8387, 8480, 8572,
    8660, 8746, 8829, 8910, 8988, 9063, 9135, 9205, 9272, 9336,
    9397, 9455, 9511, 9563, 9613, 9659, 9703, 9744, 9781, 9816,
    9848, 9877, 9903, 9925, 9945, 9962, 9976, 9986, 9994, 9998,
   10000
  };

  cmd_t    pending_cmds [$];
  bit      hold_marks [$];     // set: wait for every expected point first
  result_t expected_points [$];

  int n_items    = 0;
  int sent_items = 0;
  int gap_left   = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  polar_point_offset u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  function automatic result_t predict_point(cmd_t c);
    result_t r;
    int ang, norm, quad, sub, h, l, radius;
    r      = '0;
    ang    = int'(c.angle);
    radius = int'(c.distance);
    if (c.mode == MODE_END) begin
      norm = ang % 360;
      if (norm < 0) norm += 360;
    end else begin
      if (ang < 0 || ang > 360) begin
        r.error = 1'b1;
        return r;
      end
      norm = (ang == 360) ? 0 : ang;
    end
    quad = norm / 90;
    sub  = norm % 90;
    h = (radius * int'(quarter_sine[sub])) / 10000;
    l = (radius * int'(quarter_sine[90 - sub])) / 10000;
    if (c.mode == MODE_END) begin
      // an offset reaching the full distance is pulled in by one, even at zero
      if (h == radius) h = h - 1;
      if (l == radius) l = l - 1;
    end
    case (quad)
      0: begin
        r.point_x = 16'(int'(c.center_x) + l);
        r.point_y = 16'(int'(c.center_y) + h);
      end
      1: begin
        r.point_x = 16'(int'(c.center_x) - h);
        r.point_y = 16'(int'(c.center_y) + l);
      end
      2: begin
        r.point_x = 16'(int'(c.center_x) - l);
        r.point_y = 16'(int'(c.center_y) - h);
      end
      default: begin
        r.point_x = 16'(int'(c.center_x) + h);
        r.point_y = 16'(int'(c.center_y) - l);
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(logic m, int cx, int cy, int radius, int ang, bit hold);
    cmd_t c;
    c.mode     = m;
    c.center_x = 16'(cx);
    c.center_y = 16'(cy);
    c.distance = 8'(radius);
    c.angle    = 16'(ang);
    pending_cmds.push_back(c);
    hold_marks.push_back(hold);
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_items
    logic fired;
    bit   idle_ok;
    fired   = start && !busy;
    idle_ok = (sent_items < n_items - QUIET_TAIL) && ((sent_items / 128) % 3 != 2);
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && !fired) begin
      // item still on offer
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() == 0) begin
      start <= 1'b0;
    end else if (hold_marks[0] && (fired || expected_points.size() != 0)) begin
      start <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 3) == 0) begin
      start    <= 1'b0;
      gap_left <= $urandom_range(0, 4);
    end else begin
      cmd   <= pending_cmds.pop_front();
      void'(hold_marks.pop_front());
      start <= 1'b1;
      sent_items <= sent_items + 1;
    end
  end

  // monitor: check the strobed result first, then record the item taken
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result x=%0d y=%0d err=%0d at %0t",
                     result.point_x, result.point_y, result.error, $realtime);
        end else begin
          want = expected_points.pop_front();
          report_field("point_x", want.point_x, result.point_x);
          report_field("point_y", want.point_y, result.point_y);
          report_field("error", want.error, result.error);
        end
      end
      if (start && !busy)
        expected_points.push_back(predict_point(cmd));
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[polar_point_offset] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int  ang, radius, cx, cy, pick;
    logic m;
    // end mode: quadrant edges, wrap of signed angles, clamp and zero distance
    queue_cmd(MODE_END,  1000,  1000, 0,      0, 0);
    queue_cmd(MODE_END,  1000,  1000, 255,    0, 0);
    queue_cmd(MODE_END,     0,     0, 255,   90, 0);
    queue_cmd(MODE_END, 65535, 65535, 255,  180, 0);
    queue_cmd(MODE_END,     0, 65535, 200,  270, 0);
    queue_cmd(MODE_END,   500,   500, 100,  360, 0);
    queue_cmd(MODE_END,   500,   500, 100,   -1, 0);
    queue_cmd(MODE_END,   500,   500, 100, -360, 0);
    queue_cmd(MODE_END,   500,   500, 255, -32768, 0);
    queue_cmd(MODE_END,   500,   500, 255, 32767, 0);
    queue_cmd(MODE_END, 65535,     0, 1,     45, 0);
    queue_cmd(MODE_END,     0,     0, 0,    200, 0);
    queue_cmd(MODE_END,   300,   300, 77,   359, 0);
    // line mode: in range, 360 as zero, and angles just outside
    queue_cmd(MODE_LINE,  1000,  1000, 0,      0, 0);
    queue_cmd(MODE_LINE,  1000,  1000, 255,    0, 0);
    queue_cmd(MODE_LINE,     0,     0, 255,   90, 0);
    queue_cmd(MODE_LINE, 65535, 65535, 255,  180, 0);
    queue_cmd(MODE_LINE,     0, 65535, 128,  270, 0);
    queue_cmd(MODE_LINE,   700,   700, 255,  360, 0);
    queue_cmd(MODE_LINE,   700,   700, 255,  361, 0);
    queue_cmd(MODE_LINE,   700,   700, 255,   -1, 0);
    queue_cmd(MODE_LINE, 65535, 65535, 255, -32768, 0);
    queue_cmd(MODE_LINE, 65535, 65535, 255, 32767, 0);
    queue_cmd(MODE_LINE,    10,    10, 1,    359, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      m    = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 2)       radius = ($urandom_range(0, 1) != 0) ? 255 : 0;
      else if (pick < 3)  radius = $urandom_range(0, 3);
      else                radius = $urandom_range(0, 255);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cx = ($urandom_range(0, 1) != 0) ? 65535 : 0;
        cy = ($urandom_range(0, 1) != 0) ? 65535 : 0;
      end else begin
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
      end
      pick = $urandom_range(0, 9);
      if (m == MODE_LINE) begin
        if (pick < 7)       ang = $urandom_range(0, 360);
        else if (pick < 8)  ang = 361 - 2 * $urandom_range(0, 1) * 181;
        else                ang = int'($signed(16'($urandom)));
      end else begin
        if (pick < 6)       ang = int'($urandom_range(0, 1440)) - 720;
        else                ang = int'($signed(16'($urandom)));
      end
      // pause for a full drain before the random part and once mid-run
      queue_cmd(m, cx, cy, radius, ang, (i == 0) || (i == RANDOM_ITEMS / 2));
    end
    n_items = pending_cmds.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_points.size() != 0)
      @(posedge clk);
    repeat (TRAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_points.size() == 0)
      $display("[polar_point_offset] OK");
    else
      $display("[polar_point_offset] ERROR");
    $finish;
  end

endmodule

FILE: polar_point_offset.f
hw/rtl/ppo_pkg.sv
hw/rtl/polar_point_offset.sv
bench/polar_point_offset_tb.sv
